// File: src/gbat_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbat_pkg: shared definitions of the geometric block array translator
// Field widths, register indexes, status codes and the command and status
// bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package gbat_pkg;

  localparam int MAX_BLOCKS_DEF = 32;
  localparam int PAGE_BITS_DEF  = 48;

  localparam int RPP_W    = 13;
  localparam int INIT_W   = 21;
  localparam int GROW_W   = 5;
  localparam int MAXOFF_W = 32;
  localparam int OFF_W    = 31;
  localparam int SLOT_W   = 12;
  localparam int BLK_W    = 5;
  localparam int STATUS_W = 2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Record counts are tracked in 32 bits and saturate at 2^31, which is
  // already beyond any offset.
  localparam int REC_W = 32;
  localparam logic [REC_W-1:0] REC_CAP = 32'h8000_0000;

  // Divider: 32 dividend bits, two quotient bits per cycle.
  localparam int DIV_W     = 32;
  localparam int DIV_CNT_W = 4;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = 4'd15;

  localparam logic [RPP_W-1:0] RPP_MIN = 13'd1;
  localparam logic [RPP_W-1:0] RPP_MAX = 13'd4096;

  localparam logic [CFG_IDX_W-1:0] CFG_RPP     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GROWTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_OFF = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_OVER  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

  typedef enum logic [1:0] {
    RES_OK,
    RES_STORE,
    RES_OVER,
    RES_RANGE
  } res_kind_t;

  typedef struct packed {
    logic      load;
    logic      store;
    logic      init_walk;
    logic      step;
    logic      start_div;
    logic      div_step;
    logic      emit;
    res_kind_t kind;
  } dp_cmd_t;

  typedef struct packed {
    logic is_store;
    logic store_ok;
    logic over;
    logic hit;
    logic walk_last;
    logic div_last;
    logic out_busy;
  } dp_sts_t;

endpackage
`default_nettype wire

// File: src/gbat_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbat_dp: translator datapath
// Configuration registers, base page table, block walk accumulators,
// radix-4 restoring divider and the output register.
// ----------------------------------------------------------------------------
module gbat_dp
  import gbat_pkg::*;
#(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter int PAGE_BITS  = PAGE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  mode,
  input  wire logic [BLK_W-1:0]      block_number,
  input  wire logic [PAGE_BITS-1:0]  base_page,
  input  wire logic [OFF_W-1:0]      offset,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [PAGE_BITS-1:0]       page,
  output logic [SLOT_W-1:0]          slot,
  output logic [BLK_W-1:0]           found_block,
  output logic [STATUS_W-1:0]        status,
  input  wire dp_cmd_t               cmd,
  output dp_sts_t                    sts
);

  localparam int KW = $clog2(MAX_BLOCKS);
  localparam int BN_W = (KW > BLK_W) ? KW + 1 : BLK_W + 1;

  // Configuration registers.
  logic [RPP_W-1:0]           rpp;
  logic [INIT_W-1:0]          initial_size;
  logic [GROW_W-1:0]          growth;
  logic signed [MAXOFF_W-1:0] max_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      rpp          <= 13'd512;
      initial_size <= 21'd1;
      growth       <= 5'd2;
      max_offset   <= -32'sd1;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_RPP:     rpp          <= cfg_data[RPP_W-1:0];
        CFG_INIT:    initial_size <= cfg_data[INIT_W-1:0];
        CFG_GROWTH:  growth       <= cfg_data[GROW_W-1:0];
        CFG_MAX_OFF: max_offset   <= $signed(cfg_data[MAXOFF_W-1:0]);
        default: ;
      endcase
    end
  end

  logic [RPP_W-1:0] rpp_c;
  assign rpp_c = (rpp == '0) ? RPP_MIN : ((rpp > RPP_MAX) ? RPP_MAX : rpp);

  // Latched item.
  logic                 mode_q;
  logic [BLK_W-1:0]     blk_q;
  logic [PAGE_BITS-1:0] base_q;
  logic [OFF_W-1:0]     off_q;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q <= mode;
      blk_q  <= block_number;
      base_q <= base_page;
      off_q  <= offset;
    end
  end

  // Base page table; the user must store an entry before it is read (no check here).
  logic [PAGE_BITS-1:0] base_table [MAX_BLOCKS];
  logic [PAGE_BITS-1:0] base_rd;
  logic [KW-1:0]        k;

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      base_table[KW'(blk_q)] <= base_q;
    end
    if (cmd.start_div) begin
      base_rd <= base_table[k];
    end
  end

  // Block walk.
  logic [REC_W-1:0]        low;
  logic [REC_W-1:0]        recs;
  logic [RPP_W+INIT_W-1:0] init_prod;
  logic [REC_W+GROW_W-1:0] grow_prod;
  logic [REC_W:0]          hsum;

  assign init_prod = rpp_c * initial_size;
  assign grow_prod = recs * growth;
  assign hsum      = {1'b0, low} + {1'b0, recs};

  always_ff @(posedge clk) begin
    if (cmd.init_walk) begin
      low  <= '0;
      k    <= '0;
      recs <= (init_prod > (RPP_W+INIT_W)'(REC_CAP)) ? REC_CAP : REC_W'(init_prod);
    end else if (cmd.step) begin
      low  <= hsum[REC_W-1:0];
      k    <= k + 1'b1;
      recs <= (grow_prod > (REC_W+GROW_W)'(REC_CAP)) ? REC_CAP : REC_W'(grow_prod);
    end
  end

  // Divider: within-block offset by records per page, two bits a cycle.
  logic [DIV_W-1:0]     num;
  logic [RPP_W-1:0]     rem;
  logic [DIV_W-1:0]     quot;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_W-1:0]     num_next;
  logic [RPP_W-1:0]     rem_next;
  logic [DIV_W-1:0]     quot_next;
  logic [OFF_W-1:0]     blk_off;

  assign blk_off = off_q - low[OFF_W-1:0];

  always_comb begin
    logic [RPP_W:0] t;
    num_next  = num;
    rem_next  = rem;
    quot_next = quot;
    for (int i = 0; i < 2; i++) begin
      t        = {rem_next, num_next[DIV_W-1]};
      num_next = {num_next[DIV_W-2:0], 1'b0};
      if (t >= {1'b0, rpp_c}) begin
        rem_next  = RPP_W'(t - {1'b0, rpp_c});
        quot_next = {quot_next[DIV_W-2:0], 1'b1};
      end else begin
        rem_next  = t[RPP_W-1:0];
        quot_next = {quot_next[DIV_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_div) begin
      num  <= {1'b0, blk_off};
      rem  <= '0;
      quot <= '0;
      cnt  <= '0;
    end else if (cmd.div_step) begin
      num  <= num_next;
      rem  <= rem_next;
      quot <= quot_next;
      cnt  <= cnt + 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      case (cmd.kind)
        RES_OK: begin
          page        <= base_rd + PAGE_BITS'(quot);
          slot        <= rem[SLOT_W-1:0];
          found_block <= BLK_W'(k);
          status      <= STATUS_OK;
        end
        RES_STORE: begin
          page        <= '0;
          slot        <= '0;
          found_block <= '0;
          status      <= STATUS_OK;
        end
        RES_OVER: begin
          page        <= '0;
          slot        <= '0;
          found_block <= '0;
          status      <= STATUS_OVER;
        end
        default: begin
          page        <= '0;
          slot        <= '0;
          found_block <= '0;
          status      <= STATUS_RANGE;
        end
      endcase
    end
  end

  assign sts.is_store  = !mode_q;
  assign sts.store_ok  = BN_W'(blk_q) < BN_W'(MAX_BLOCKS);
  assign sts.over      = $signed({1'b0, off_q}) > max_offset;
  assign sts.hit       = {2'b00, off_q} < hsum;
  assign sts.walk_last = (k == KW'(MAX_BLOCKS - 1));
  assign sts.div_last  = (cnt == DIV_LAST);
  assign sts.out_busy  = out_valid && out_stall;

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STATUS_OK |-> page == '0 && slot == '0 && found_block == '0)
    else $error("error result carries nonzero page, slot or block");

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    cmd.emit && cmd.kind == RES_OK |-> rem < rpp_c)
    else $error("divider remainder not below records per page");

  a_walk_index: assert property (@(posedge clk) disable iff (rst)
    cmd.start_div |-> (KW + 1)'(k) < (KW + 1)'(MAX_BLOCKS))
    else $error("table read past the last block");

endmodule
`default_nettype wire

// File: src/gbat_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbat_ctrl: translator controller
// Sequences check, block walk, division and result hand-off for one item.
// ----------------------------------------------------------------------------
module gbat_ctrl
  import gbat_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_stall,
  output dp_cmd_t      cmd,
  input  wire dp_sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_WALK,
    S_DIV,
    S_FINISH
  } state_t;

  state_t    state;
  state_t    state_next;
  res_kind_t kind;
  res_kind_t kind_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.kind   = kind;
    state_next = state;
    kind_next  = kind;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.is_store) begin
          cmd.store  = sts.store_ok;
          kind_next  = sts.store_ok ? RES_STORE : RES_RANGE;
          state_next = S_FINISH;
        end else if (sts.over) begin
          kind_next  = RES_OVER;
          state_next = S_FINISH;
        end else begin
          cmd.init_walk = 1'b1;
          state_next    = S_WALK;
        end
      end
      S_WALK: begin
        if (sts.hit) begin
          cmd.start_div = 1'b1;
          state_next    = S_DIV;
        end else if (sts.walk_last) begin
          kind_next  = RES_RANGE;
          state_next = S_FINISH;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          kind_next  = RES_OK;
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!sts.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      kind  <= RES_OK;
    end else begin
      state <= state_next;
      kind  <= kind_next;
    end
  end

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV && sts.div_last |=> state == S_FINISH)
    else $error("division did not hand over to the finish state");

  a_ok_after_div: assert property (@(posedge clk) disable iff (rst)
    state == S_FINISH && kind == RES_OK |-> $past(state == S_DIV) || $past(state == S_FINISH))
    else $error("good result without a division");

endmodule
`default_nettype wire

// File: src/geometric_block_array_translate.sv
`default_nettype none
// ----------------------------------------------------------------------------
// geometric_block_array_translate: record offset to page and slot translator
// Walks the geometric blocks of a growable array to find the block holding
// a record offset, then splits the in-block offset into page and slot.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid / in_stall) carries one transaction per item.
//   A store transaction (mode 0) writes a block's base page into the table;
//   a translate transaction (mode 1) looks up an offset. Every transaction
//   yields exactly one result on the output channel (out_valid / out_stall).
//   The configuration port is a plain write port (cfg_write, cfg_index,
//   cfg_data) that the user must write only while the block is idle; the
//   block makes no check of this. A store is checked and its result handed
//   straight to the output register. A lookup walks the blocks in order,
//   with one add-and-compare step per block, until the offset falls inside
//   a block, then runs the radix-4 divider. Range errors on a store return
//   straight after the check, and on a lookup when the walk runs out of
//   blocks.
//   Results sit in an output register, so the next transaction is taken
//   while an earlier result is still stalled; a new result waits in the
//   finish state until the register frees up.
//   Reset restores the register defaults and empties the output; the base
//   page table is not cleared and each entry must be stored before use.
// ----------------------------------------------------------------------------
module geometric_block_array_translate
  import gbat_pkg::*;
#(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter int PAGE_BITS  = PAGE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  mode,
  input  wire logic [BLK_W-1:0]      block_number,
  input  wire logic [PAGE_BITS-1:0]  base_page,
  input  wire logic [OFF_W-1:0]      offset,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [PAGE_BITS-1:0]       page,
  output logic [SLOT_W-1:0]          slot,
  output logic [BLK_W-1:0]           found_block,
  output logic [STATUS_W-1:0]        status
);

  // The controller only sees summarized status from the datapath and
  // drives it through one command bundle.
  dp_cmd_t cmd;
  dp_sts_t sts;

  gbat_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  gbat_dp #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .PAGE_BITS  (PAGE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mode         (mode),
    .block_number (block_number),
    .base_page    (base_page),
    .offset       (offset),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .page         (page),
    .slot         (slot),
    .found_block  (found_block),
    .status       (status),
    .cmd          (cmd),
    .sts          (sts)
  );

endmodule
`default_nettype wire
